// ===== rtl/core/cic_pkg.sv =====
// shared types and the saturating add for the chapter interval coalescer
`timescale 1ns / 1ps
package cic_pkg;
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] chapter_frame;
    } cic_in_t;

    typedef struct packed {
        logic [31:0] cluster_first;
        logic [31:0] cluster_pages;
        logic        target_reached;
        logic        table_full;
    } cic_out_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } cic_entry_t;

    function automatic logic [31:0] cic_sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage

// ===== rtl/core/chapter_interval_coalescer_unit.sv =====
// top level of the chapter interval coalescer
`timescale 1ns / 1ps
// Cluster table in one synchronous memory, walked by a sequencer entry by
// entry. An add beat scans entries up to the insertion point, then shifts
// later entries on an insert or a merge of two clusters; a clear needs no
// table walk. The sequencer is paced by the single memory port pair (one
// read, one write). One item is in flight at a time; the result sits in an
// output register and the next beat is taken once it is handed off.
module chapter_interval_coalescer_unit #(
    parameter int MAX_CLUSTERS      = 16,
    parameter int PAGES_PER_CHAPTER = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  cic_pkg::cic_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cic_pkg::cic_out_t m_data
);
    import cic_pkg::*;

    localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam logic [31:0] CP = 32'(PAGES_PER_CHAPTER);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SCAN   = 10'b0000000010,
        ST_SCANW  = 10'b0000000100,
        ST_PREV   = 10'b0000001000,
        ST_DECIDE = 10'b0000010000,
        ST_INSR   = 10'b0000100000,
        ST_INSW   = 10'b0001000000,
        ST_REMR   = 10'b0010000000,
        ST_REMW   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] target_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] pos_reg, pos_next;   // scan index / shift index
    logic [31:0] frame_reg, frame_next;
    cic_entry_t cur_reg, cur_next;      // entry at pos
    cic_entry_t prv_reg, prv_next;      // entry at pos-1
    cic_entry_t hold_reg, hold_next;    // entry carried along while shifting
    logic cur_ok_reg, cur_ok_next;
    logic m_valid_reg, m_valid_next;
    cic_out_t m_data_reg, m_data_next;
    logic [47:0] tgt_pages;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    cic_entry_t wr_data, rd_data;

    cic_mem #(.DEPTH(MAX_CLUSTERS), .AW(AW)) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign tgt_pages = 48'(target_reg) * 48'(CP);
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    function automatic cic_out_t mk_res(input cic_entry_t e, input logic [47:0] t);
        cic_out_t r;
        r.cluster_first  = e.start;
        r.cluster_pages  = e.length;
        r.target_reached = ({16'd0, e.length} >= t);
        r.table_full     = 1'b0;
        return r;
    endfunction

    logic [32:0] chap_end, prv_end;
    assign chap_end = {1'b0, frame_reg} + {1'b0, CP};
    assign prv_end  = {1'b0, prv_reg.start} + {1'b0, prv_reg.length};

    always_comb begin
        cic_entry_t merged;
        state_next = state_reg; used_next = used_reg; pos_next = pos_reg;
        frame_next = frame_reg; cur_next = cur_reg; prv_next = prv_reg;
        hold_next = hold_reg; cur_ok_next = cur_ok_reg;
        m_valid_next = m_valid_reg; m_data_next = m_data_reg;
        wr_en = 1'b0; wr_addr = pos_reg[AW-1:0]; wr_data = hold_reg;
        rd_addr = pos_reg[AW-1:0];
        merged = cur_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    frame_next = s_data.chapter_frame;
                    pos_next = '0;
                    if (s_data.opcode == OP_CLEAR) begin
                        used_next = '0;
                        m_data_next = '0;
                        m_valid_next = 1'b1;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read entry pos, result arrives next cycle
                if (pos_reg < used_reg) begin
                    state_next = ST_SCANW;
                end else begin
                    cur_ok_next = 1'b0;
                    state_next = (pos_reg != '0) ? ST_PREV : ST_DECIDE;
                end
            end
            ST_SCANW: begin
                if (rd_data.start <= frame_reg) begin
                    prv_next = rd_data;
                    pos_next = pos_reg + 1'b1;
                    state_next = ST_SCAN;
                    rd_addr = pos_next[AW-1:0];
                end else begin
                    cur_next = rd_data;
                    cur_ok_next = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_PREV: state_next = ST_DECIDE;   // prv_reg already holds pos-1
            ST_DECIDE: begin
                if (cur_ok_reg && chap_end == {1'b0, cur_reg.start}) begin
                    merged.start = frame_reg;
                    merged.length = cic_sat_add(cur_reg.length, CP);
                    if (pos_reg != '0 && prv_end == {1'b0, frame_reg}) begin
                        merged.start = prv_reg.start;
                        merged.length = cic_sat_add(merged.length, prv_reg.length);
                        // write merged at pos-1, then pull later entries down
                        wr_en = 1'b1;
                        wr_addr = AW'(pos_reg - 1'b1);
                        wr_data = merged;
                        m_data_next = mk_res(merged, tgt_pages);
                        used_next = used_reg - 1'b1;
                        pos_next = pos_reg;
                        state_next = ST_REMR;
                    end else begin
                        wr_en = 1'b1;
                        wr_data = merged;
                        m_data_next = mk_res(merged, tgt_pages);
                        state_next = ST_DONE;
                    end
                end else if (pos_reg != '0 && prv_end == {1'b0, frame_reg}) begin
                    merged = prv_reg;
                    merged.length = cic_sat_add(prv_reg.length, CP);
                    wr_en = 1'b1;
                    wr_addr = AW'(pos_reg - 1'b1);
                    wr_data = merged;
                    m_data_next = mk_res(merged, tgt_pages);
                    state_next = ST_DONE;
                end else if (used_reg >= CW'(MAX_CLUSTERS)) begin
                    m_data_next = '0;
                    m_data_next.table_full = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    merged.start = frame_reg;
                    merged.length = CP;
                    wr_en = 1'b1;
                    wr_data = merged;
                    m_data_next = mk_res(merged, tgt_pages);
                    hold_next = cur_reg;
                    used_next = used_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                    state_next = cur_ok_reg ? ST_INSR : ST_DONE;
                end
            end
            ST_INSR: begin
                // hold_reg is the displaced entry bound for pos; read old pos
                if (pos_reg < used_reg - 1'b1) state_next = ST_INSW;
                else begin
                    wr_en = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_INSW: begin
                wr_en = 1'b1;
                hold_next = rd_data;
                pos_next = pos_reg + 1'b1;
                state_next = ST_INSR;
            end
            ST_REMR: begin
                // move entry pos+1 down to pos; pos starts at the slot of the absorbed entry
                if (pos_reg < used_reg) begin
                    rd_addr = AW'(pos_reg + 1'b1);
                    state_next = ST_REMW;
                end else state_next = ST_DONE;
            end
            ST_REMW: begin
                wr_en = 1'b1;
                wr_data = rd_data;
                pos_next = pos_reg + 1'b1;
                state_next = ST_REMR;
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            m_valid_reg <= 1'b0;
            target_reg <= 16'd1;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) target_reg <= cfg_wdata;
        end
        pos_reg <= pos_next; frame_reg <= frame_next; cur_reg <= cur_next;
        prv_reg <= prv_next; hold_reg <= hold_next; cur_ok_reg <= cur_ok_next;
        m_data_reg <= m_data_next;
    end
endmodule

// ===== rtl/core/cic_mem.sv =====
// cluster table memory, one write and one registered read port
`timescale 1ns / 1ps
module cic_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  cic_pkg::cic_entry_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output cic_pkg::cic_entry_t rd_data
);
    import cic_pkg::*;

    cic_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/core/cic_checker.sv =====
// port-level checks for the coalescer, bound to the top level
`timescale 1ns / 1ps
module cic_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cic_pkg::cic_out_t m_data
);
    import cic_pkg::*;

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> m_data.cluster_pages == 32'd0)
        else $error("full result carries data");
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while busy");
    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken with result pending");
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped");
endmodule

bind chapter_interval_coalescer_unit cic_checker u_cic_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== verif/testbench.sv =====
// self-checking testbench for the chapter interval coalescer
`timescale 1ns / 1ps
module testbench;
    import cic_pkg::*;

    localparam int NCLUST = 16;
    localparam int CPAGES = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 4 * NCLUST + 20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    cic_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    cic_out_t    m_data;

    chapter_interval_coalescer_unit #(
        .MAX_CLUSTERS     (NCLUST),
        .PAGES_PER_CHAPTER(CPAGES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // predictor copy of the cluster table
    logic [31:0] tbl_start [NCLUST];
    logic [31:0] tbl_len   [NCLUST];
    int          tbl_used;
    logic [15:0] tgt_chapters;

    cic_out_t    expected_results[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          idle_pct;
    bit          hold_off;
    int          quiet_cycles;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] sat_sum(input logic [32:0] v);
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic cic_out_t coalesce_chapter(input cic_in_t beat);
        cic_out_t    r;
        int          pos;
        int          hit;
        logic [32:0] chap_end;
        logic [32:0] prev_end;
        r = '0;
        if (beat.opcode == OP_CLEAR) begin
            tbl_used = 0;
            return r;
        end
        chap_end = {1'b0, beat.chapter_frame} + 33'(CPAGES);
        pos = 0;
        while (pos < tbl_used && tbl_start[pos] <= beat.chapter_frame) pos++;
        prev_end = (pos > 0) ? ({1'b0, tbl_start[pos-1]} + {1'b0, tbl_len[pos-1]}) : '0;
        if (pos < tbl_used && chap_end == {1'b0, tbl_start[pos]}) begin
            tbl_start[pos] = beat.chapter_frame;
            tbl_len[pos] = sat_sum({1'b0, tbl_len[pos]} + 33'(CPAGES));
            hit = pos;
            if (pos > 0 && prev_end == {1'b0, tbl_start[pos]}) begin
                tbl_start[pos] = tbl_start[pos-1];
                tbl_len[pos] = sat_sum({1'b0, tbl_len[pos]} + {1'b0, tbl_len[pos-1]});
                for (int k = pos - 1; k + 1 < tbl_used; k++) begin
                    tbl_start[k] = tbl_start[k+1];
                    tbl_len[k] = tbl_len[k+1];
                end
                tbl_used--;
                hit = pos - 1;
            end
        end else if (pos > 0 && prev_end == {1'b0, beat.chapter_frame}) begin
            hit = pos - 1;
            tbl_len[hit] = sat_sum({1'b0, tbl_len[hit]} + 33'(CPAGES));
        end else begin
            if (tbl_used >= NCLUST) begin
                r.table_full = 1'b1;
                return r;
            end
            for (int k = tbl_used; k > pos; k--) begin
                tbl_start[k] = tbl_start[k-1];
                tbl_len[k] = tbl_len[k-1];
            end
            tbl_start[pos] = beat.chapter_frame;
            tbl_len[pos] = 32'(CPAGES);
            tbl_used++;
            hit = pos;
        end
        r.cluster_first = tbl_start[hit];
        r.cluster_pages = tbl_len[hit];
        r.target_reached = (64'(tbl_len[hit]) >= 64'(tgt_chapters) * 64'(CPAGES));
        return r;
    endfunction

    // sender: one beat, random idle before it
    task automatic send_beat(input logic op, input logic [31:0] frame);
        cic_in_t b;
        b.opcode = op;
        b.chapter_frame = frame;
        // valid drops between beats, the block is busy then anyway
        @(posedge aclk);
        while ($urandom_range(99) < idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(coalesce_chapter(b));
        beats_sent++;
        s_valid <= 1'b0;
    endtask

    task automatic add_chapter(input logic [31:0] frame);
        send_beat(OP_ADD, frame);
    endtask

    task automatic clear_table();
        send_beat(OP_CLEAR, $urandom);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register writes only while idle
    task automatic write_target(input logic [15:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tgt_chapters = v;
    endtask

    // result checker with its own receiver stall
    always @(posedge aclk) begin
        cic_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.cluster_first !== exp_r.cluster_first) begin
                    $display("%0t: cluster_first exp %h got %h", $time,
                             exp_r.cluster_first, m_data.cluster_first);
                    errors++;
                end
                if (m_data.cluster_pages !== exp_r.cluster_pages) begin
                    $display("%0t: cluster_pages exp %h got %h", $time,
                             exp_r.cluster_pages, m_data.cluster_pages);
                    errors++;
                end
                if (m_data.target_reached !== exp_r.target_reached) begin
                    $display("%0t: target_reached exp %b got %b", $time,
                             exp_r.target_reached, m_data.target_reached);
                    errors++;
                end
                if (m_data.table_full !== exp_r.table_full) begin
                    $display("%0t: table_full exp %b got %b", $time,
                             exp_r.table_full, m_data.table_full);
                    errors++;
                end
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL chapter_interval_coalescer_unit");
            $finish;
        end
    end

    task automatic test_directed();
        clear_table();
        add_chapter(32'h0000_0000);
        add_chapter(32'h0000_0800);
        // fill the gap: prepend and merge
        add_chapter(32'h0000_0400);
        // append to the merged cluster
        add_chapter(32'h0000_0C00);
        // high end: cluster runs past the top frame
        add_chapter(32'hFFFF_FC00);
        add_chapter(32'hFFFF_FFFF);
        add_chapter(32'hFFFF_F800);
        add_chapter(32'h8000_0000);
        // duplicate frame
        add_chapter(32'h8000_0000);
        add_chapter(32'h7FFF_FFFF);
        clear_table();
        // fill the table, then overflow it
        for (int i = 0; i < NCLUST; i++) add_chapter(32'(i) * 32'h0001_0000);
        add_chapter(32'h5555_5555);
        add_chapter(32'h0000_0400);
        clear_table();
    endtask

    task automatic test_targets();
        logic [15:0] vals[4] = '{16'd0, 16'd2, 16'd3, 16'hFFFF};
        foreach (vals[i]) begin
            write_target(vals[i]);
            clear_table();
            for (int j = 0; j < 4; j++) add_chapter(32'h0010_0000 + 32'(j) * CPAGES);
            add_chapter(32'hAAAA_AAAA);
        end
        write_target(16'd1);
    endtask

    // mostly chapters near a moving base so they touch, some noise
    task automatic test_random(input int count);
        logic [31:0] base;
        int          sel;
        base = $urandom;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 3)
                clear_table();
            else if (sel < 12)
                add_chapter($urandom);
            else if (sel < 15)
                add_chapter(32'hFFFF_FFFF - 32'($urandom_range(8 * CPAGES)));
            else begin
                if ($urandom_range(49) == 0) base = $urandom;
                add_chapter(base + 32'($urandom_range(12)) * CPAGES);
            end
            if (i % 150 == 149) write_target(16'($urandom_range(1, 12)));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++) add_chapter(32'h0200_0000 + 32'(i) * CPAGES);
        join
        wait_drained();
    endtask

    initial begin
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        idle_pct = 27;
        tbl_used = 0;
        tgt_chapters = 16'd1;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_targets();
        test_random(250);
        idle_pct = 0;
        test_random(120);
        idle_pct = 27;
        test_backpressure();
        test_random(200);

        wait_drained();
        $display("covered %0d beats, %0d results: merges, appends, inserts, overflow,",
                 beats_sent, results_seen);
        $display("clears, target settings 0 to 65535, stalls and idle gaps");
        if (errors == 0) begin
            $display("PASS chapter_interval_coalescer_unit");
        end else begin
            $display("FAIL chapter_interval_coalescer_unit");
        end
        $finish;
    end
endmodule
